### rtl/core/swdh_pkg.sv
// ----------------------------------------------------------------------------
// swdh_pkg: shared types and constants for the SWD host transaction engine
// Phase codes, ACK codes, status codes and the state/result records.
// ----------------------------------------------------------------------------
package swdh_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_REQ   = 3'd1,
		PH_TRN   = 3'd2,
		PH_ACK   = 3'd3,
		PH_RDATA = 3'd4,
		PH_WTRN  = 3'd5,
		PH_WDATA = 3'd6,
		PH_TRAIL = 3'd7
	} swdh_phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FAULT  = 2'd1,
		ST_PROTO  = 2'd2,
		ST_PARITY = 2'd3
	} swdh_status_t;

	// ACK as assembled: first sampled bit lands in bit 2
	localparam logic [2:0] ACK_OK    = 3'b100;
	localparam logic [2:0] ACK_WAIT  = 3'b010;
	localparam logic [2:0] ACK_FAULT = 3'b001;

	localparam logic [5:0] DATA_BITS  = 6'd32;
	localparam logic [5:0] REQ_BITS   = 6'd8;
	localparam logic [5:0] ACK_BITS   = 6'd3;
	localparam logic [5:0] TRAIL_BITS = 6'd2;

	// Request byte fixed bits: start (bit 7) and park (bit 0)
	localparam logic [7:0] REQ_FRAME  = 8'h81;

	typedef struct packed {
		swdh_phase_t phase;
		logic [5:0]  bit_count;
		logic [7:0]  request_byte;
		logic [31:0] data_shift;
		logic [2:0]  ack_bits;
		logic        parity_acc;
		logic        is_read;
	} swdh_state_t;

	typedef struct packed {
		logic         line_out;
		logic         line_drive;
		logic         busy_res;
		logic         done_res;
		swdh_status_t status;
		logic [31:0]  read_data;
	} swdh_result_t;

endpackage

### rtl/core/swdh_step.sv
// ----------------------------------------------------------------------------
// swdh_step: one SWD bit step
// Next state and result word for one start or tick word, purely combinational.
// ----------------------------------------------------------------------------
module swdh_step
	import swdh_pkg::*;
(
	input  swdh_state_t  cur,
	input  logic         kind,
	input  logic         ap_sel,
	input  logic         read_op,
	input  logic [1:0]   reg_addr,
	input  logic [31:0]  write_data,
	input  logic         line_in,
	output swdh_state_t  nxt,
	output swdh_result_t res
);

	logic [5:0] cnt_inc;
	logic [2:0] ack_new;
	logic       req_par;

	assign cnt_inc = cur.bit_count + 6'd1;
	assign ack_new = {cur.ack_bits[1:0], line_in};
	assign req_par = ap_sel ^ read_op ^ reg_addr[0] ^ reg_addr[1];

	always_comb begin
		nxt            = cur;
		res.line_out   = 1'b0;
		res.line_drive = 1'b0;
		res.done_res   = 1'b0;
		res.status     = ST_OK;
		res.read_data  = '0;
		if (!kind) begin
			nxt.request_byte = REQ_FRAME | {1'b0, ap_sel, read_op, reg_addr[0],
				reg_addr[1], req_par, 2'b00};
			nxt.is_read    = read_op;
			nxt.data_shift = write_data;
			nxt.bit_count  = '0;
			nxt.ack_bits   = '0;
			nxt.parity_acc = 1'b0;
			nxt.phase      = PH_REQ;
		end else begin
			case (cur.phase)
				PH_IDLE: begin
				end
				PH_REQ: begin
					res.line_drive = 1'b1;
					res.line_out   = cur.request_byte[3'd7 - cur.bit_count[2:0]];
					nxt.bit_count  = cnt_inc;
					if (cnt_inc >= REQ_BITS) begin
						nxt.bit_count = '0;
						nxt.phase     = PH_TRN;
					end
				end
				PH_TRN: begin
					nxt.bit_count = '0;
					nxt.ack_bits  = '0;
					nxt.phase     = PH_ACK;
				end
				PH_ACK: begin
					nxt.ack_bits  = ack_new;
					nxt.bit_count = cnt_inc;
					if (cnt_inc >= ACK_BITS) begin
						nxt.bit_count  = '0;
						nxt.parity_acc = 1'b0;
						if (ack_new == ACK_OK) begin
							if (cur.is_read) begin
								nxt.data_shift = '0;
								nxt.phase      = PH_RDATA;
							end else begin
								nxt.phase = PH_WTRN;
							end
						end else if (ack_new == ACK_WAIT) begin
							nxt.phase = PH_REQ;
						end else begin
							res.done_res = 1'b1;
							res.status   = (ack_new == ACK_FAULT) ? ST_FAULT : ST_PROTO;
							nxt.phase    = PH_IDLE;
						end
					end
				end
				PH_RDATA: begin
					nxt.parity_acc = cur.parity_acc ^ line_in;
					if (cur.bit_count < DATA_BITS) begin
						nxt.data_shift = {line_in, cur.data_shift[31:1]};
						nxt.bit_count  = cnt_inc;
					end else begin
						nxt.bit_count = '0;
						nxt.phase     = PH_TRAIL;
					end
				end
				PH_WTRN: begin
					nxt.bit_count  = '0;
					nxt.parity_acc = 1'b0;
					nxt.phase      = PH_WDATA;
				end
				PH_WDATA: begin
					res.line_drive = 1'b1;
					if (cur.bit_count < DATA_BITS) begin
						res.line_out   = cur.data_shift[0];
						nxt.parity_acc = cur.parity_acc ^ cur.data_shift[0];
						nxt.data_shift = {1'b0, cur.data_shift[31:1]};
						nxt.bit_count  = cnt_inc;
					end else begin
						res.line_out   = cur.parity_acc;
						nxt.parity_acc = 1'b0;
						nxt.bit_count  = '0;
						nxt.phase      = PH_TRAIL;
					end
				end
				PH_TRAIL: begin
					res.line_drive = ~cur.is_read;
					nxt.bit_count  = cnt_inc;
					if (cnt_inc >= TRAIL_BITS) begin
						res.done_res = 1'b1;
						if (cur.is_read) begin
							if (cur.parity_acc) res.status    = ST_PARITY;
							else                res.read_data = cur.data_shift;
						end
						nxt.bit_count = '0;
						nxt.phase     = PH_IDLE;
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end
		res.busy_res = (nxt.phase != PH_IDLE);
	end

endmodule

### rtl/core/swd_host_transaction_engine_top.sv
// ----------------------------------------------------------------------------
// swd_host_transaction_engine_top: SWD host transaction engine
// Start words latch a request; each tick word advances the SWD bit sequence
// by one SWCLK period and returns one result word (line level, drive enable,
// busy/done, status and read data).
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid / in_ready | kind ap_sel read_op reg_addr write_data
//           |                     | line_in
//   output  | out_valid/out_ready | line_out line_drive busy_res done_res
//           |                     | status read_data
//
// - One word in, one word out; a new input word is taken every clock cycle
//   while the output is not stalled. The bit step runs combinationally from
//   the accepted word and the current state straight into the state registers
//   and the result register. in_ready is high whenever the result register is
//   empty or is being drained in the same cycle, so a stalled output stalls the input only.
// - arst_n clears the state (phase idle, counters and shifters zero) and
//   empties the result register.
// ----------------------------------------------------------------------------
module swd_host_transaction_engine_top
	import swdh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic        ap_sel,
	input  logic        read_op,
	input  logic [1:0]  reg_addr,
	input  logic [31:0] write_data,
	input  logic        line_in,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        line_out,
	output logic        line_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [31:0] read_data
);

	swdh_state_t  state_q;
	swdh_state_t  state_nxt;
	swdh_result_t res_nxt;
	swdh_result_t res_q;
	logic         out_valid_q;
	logic         accept;

	// output slot frees up in the same cycle it is drained
	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;

	swdh_step u_step (
		.cur        (state_q),
		.kind       (kind),
		.ap_sel     (ap_sel),
		.read_op    (read_op),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.line_in    (line_in),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	// transaction state: advances only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, default: '0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_out   = res_q.line_out;
	assign line_drive = res_q.line_drive;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign status     = res_q.status;
	assign read_data  = res_q.read_data;

endmodule
